FILE: design/smrc_pkg.sv
// shared types, widths and register indexes for the mixed-radix converter
package smrc_pkg;

  // field widths
  localparam int unsigned RES_W      = 15;
  localparam int unsigned MOD_W      = 15;
  localparam int unsigned INV_W      = 16;
  localparam int unsigned DIFF_W     = 16;
  localparam int unsigned PROD_W     = DIFF_W + INV_W;
  localparam int unsigned MAG_W      = PROD_W;
  localparam int unsigned OUT_W      = 62;
  localparam int unsigned W2_W       = 2 * MOD_W;
  localparam int unsigned W3_W       = 3 * MOD_W;

  // remainder unit: bits retired per stage and resulting latency
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = MAG_W / DIV_BITS;
  localparam int unsigned RED_LAT    = DIV_STAGES + 3;

  // stream and configuration port widths
  localparam int unsigned S_TDATA_W  = 64;
  localparam int unsigned M_TDATA_W  = 64;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 48;

  typedef logic signed [RES_W-1:0]  res_t;
  typedef logic        [MOD_W-1:0]  mod_t;
  typedef logic signed [INV_W-1:0]  inv_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  // digits carried alongside the remainder units
  typedef struct packed {
    res_t d0;
    res_t d1;
    res_t d2;
  } digits_t;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODULUS_0       = 3'd0,
    CFG_MODULUS_1       = 3'd1,
    CFG_MODULUS_2       = 3'd2,
    CFG_MODULUS_3       = 3'd3,
    CFG_INVERSE_INTO_1  = 3'd4,
    CFG_INVERSES_INTO_2 = 3'd5,
    CFG_INVERSES_INTO_3 = 3'd6
  } cfg_idx_e;

endpackage

FILE: design/smrc_mulred.sv
// pipelined multiply and symmetric reduction modulo a configured modulus
module smrc_mulred (
  input  logic                clk_i,
  input  logic                en_i,
  input  smrc_pkg::diff_t     diff_i,
  input  smrc_pkg::inv_t      inv_i,
  input  smrc_pkg::mod_t      mod_i,
  output smrc_pkg::res_t      res_o
);

  logic signed [smrc_pkg::PROD_W-1:0] prod_q;
  logic [smrc_pkg::MAG_W-1:0] mag_q [smrc_pkg::DIV_STAGES+1];
  logic                       neg_q [smrc_pkg::DIV_STAGES+1];
  logic [smrc_pkg::MOD_W-1:0] rem_q [smrc_pkg::DIV_STAGES:1];
  smrc_pkg::res_t             res_q;

  // product of difference and inverse
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= diff_i * inv_i;
    end
  end

  // sign and magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= prod_q[smrc_pkg::PROD_W-1];
      mag_q[0] <= prod_q[smrc_pkg::PROD_W-1] ? smrc_pkg::MAG_W'(-prod_q)
                                             : smrc_pkg::MAG_W'(prod_q);
    end
  end

  // restoring remainder, a few bits per stage
  for (genvar k = 0; k < smrc_pkg::DIV_STAGES; k++) begin : g_div
    logic [smrc_pkg::MOD_W-1:0] rem_in;
    logic [smrc_pkg::MOD_W-1:0] rem_d;
    logic [smrc_pkg::MAG_W-1:0] mag_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k];
    end

    always_comb begin
      logic [smrc_pkg::MOD_W:0] t;
      rem_d = rem_in;
      mag_d = mag_q[k];
      for (int b = 0; b < smrc_pkg::DIV_BITS; b++) begin
        t     = {rem_d, mag_d[smrc_pkg::MAG_W-1]};
        mag_d = {mag_d[smrc_pkg::MAG_W-2:0], 1'b0};
        if (t >= {1'b0, mod_i}) begin
          t = t - {1'b0, mod_i};
        end
        rem_d = t[smrc_pkg::MOD_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        mag_q[k+1] <= mag_d;
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  // fold into the symmetric range, sign follows the dividend unless the remainder exceeds half the modulus
  always_ff @(posedge clk_i) begin
    logic signed [smrc_pkg::MOD_W+1:0] pr;
    logic signed [smrc_pkg::MOD_W+1:0] pm;
    logic signed [smrc_pkg::MOD_W+1:0] val;
    if (en_i) begin
      pr = {2'b00, rem_q[smrc_pkg::DIV_STAGES]};
      pm = {2'b00, mod_i};
      if (mod_i == '0) begin
        val = '0;
      end else if (rem_q[smrc_pkg::DIV_STAGES] > (mod_i >> 1)) begin
        val = neg_q[smrc_pkg::DIV_STAGES] ? (pm - pr) : (pr - pm);
      end else begin
        val = neg_q[smrc_pkg::DIV_STAGES] ? -pr : pr;
      end
      res_q <= val[smrc_pkg::RES_W-1:0];
    end
  end

  assign res_o = res_q;

endmodule

FILE: design/smrc_delay.sv
// delay line for valid bits and digits alongside one reduction level
module smrc_delay (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  smrc_pkg::digits_t data_i,
  output logic              valid_o,
  output smrc_pkg::digits_t data_o
);

  logic              valid_q [smrc_pkg::RED_LAT];
  smrc_pkg::digits_t data_q  [smrc_pkg::RED_LAT];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < smrc_pkg::RED_LAT; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < smrc_pkg::RED_LAT; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= data_i;
      for (int k = 1; k < smrc_pkg::RED_LAT; k++) begin
        data_q[k] <= data_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[smrc_pkg::RED_LAT-1];
  assign data_o  = data_q[smrc_pkg::RED_LAT-1];

endmodule

FILE: design/smrc_accum.sv
// weighting of the mixed-radix digits and final sum
module smrc_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  smrc_pkg::digits_t             digits_i,
  input  smrc_pkg::res_t                d3_i,
  input  smrc_pkg::mod_t                w1_i,
  input  logic [smrc_pkg::W2_W-1:0]     w2_i,
  input  logic [smrc_pkg::W3_W-1:0]     w3_i,
  output logic                          valid_o,
  output logic [smrc_pkg::OUT_W-1:0]    value_o
);

  localparam int unsigned T1_W = smrc_pkg::MOD_W + 1 + smrc_pkg::RES_W;
  localparam int unsigned T2_W = smrc_pkg::W2_W + 1 + smrc_pkg::RES_W;
  localparam int unsigned T3_W = smrc_pkg::W3_W + 1 + smrc_pkg::RES_W;

  logic                          va_q, vb_q;
  smrc_pkg::res_t                d0_q;
  logic signed [T1_W-1:0]        t1_q;
  logic signed [T2_W-1:0]        t2_q;
  logic signed [T3_W-1:0]        t3_q;
  logic [smrc_pkg::OUT_W-1:0]    sum_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  // digit times weight
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d0_q <= digits_i.d0;
      t1_q <= $signed({1'b0, w1_i}) * digits_i.d1;
      t2_q <= $signed({1'b0, w2_i}) * digits_i.d2;
      t3_q <= $signed({1'b0, w3_i}) * d3_i;
    end
  end

  // sum, wrapping at the output width
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= smrc_pkg::OUT_W'(d0_q) + smrc_pkg::OUT_W'(t1_q)
             + smrc_pkg::OUT_W'(t2_q) + smrc_pkg::OUT_W'(t3_q);
    end
  end

  assign valid_o = vb_q;
  assign value_o = sum_q;

endmodule

FILE: design/symmetric_mixed_radix_conversion.sv
// top level of the symmetric residue to binary mixed-radix converter
//
// Residues enter on the s_axis channel, four 15-bit signed fields per
// transaction; the signed 62-bit integer leaves on m_axis, one transaction
// per input. The user must write moduli and inverses through cfg_we_i/cfg_addr_i/
// cfg_wdata_i only while no conversion is in flight; the block does not enforce it.
// The path holds 3 * 11 + 3 = 36 register stages: three reduction levels in
// series, each one multiply, one magnitude stage, eight remainder stages of
// four bits and one folding stage, then two stages of weighting and summing
// and the output register.
// Throughput is one transaction per cycle while the skid register is empty;
// every stage takes a new item each clock unless the pipeline holds.
// Reset clears all valid bits and loads the default base 7, 9, 11, 13.
// When the receiver stalls, the finished value waits in the output register
// and one further value is caught in a skid register; the pipeline holds
// and s_axis_tready drops only once that skid register is full.
module symmetric_mixed_radix_conversion (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // residue_0, residue_1, residue_2, residue_3, zero fill
  input  logic [smrc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // binary_value, zero fill
  output logic [smrc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [smrc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [smrc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  smrc_pkg::mod_t            mod0_q, mod1_q, mod2_q, mod3_q;
  logic [smrc_pkg::MOD_W-1:0]  inv1_q;
  logic [2*smrc_pkg::INV_W-1:0] inv2_q;
  logic [3*smrc_pkg::INV_W-1:0] inv3_q;
  logic [smrc_pkg::W2_W-1:0] w2_q;
  logic [smrc_pkg::W3_W-1:0] w3_q;

  logic en;
  smrc_pkg::res_t r0, r1, r2, r3;
  smrc_pkg::res_t d1, t20, t30, d2, t31, d3;
  smrc_pkg::digits_t dg_in0, dg_out0, dg_in1, dg_out1, dg_in2, dg_out2;
  logic v0, v1, v2;
  logic acc_valid;
  logic [smrc_pkg::OUT_W-1:0] acc_value;

  logic                       out_valid_q, skid_valid_q;
  logic [smrc_pkg::OUT_W-1:0] out_q, skid_q;
  logic                       out_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod0_q <= smrc_pkg::MOD_W'(7);
      mod1_q <= smrc_pkg::MOD_W'(9);
      mod2_q <= smrc_pkg::MOD_W'(11);
      mod3_q <= smrc_pkg::MOD_W'(13);
      inv1_q <= smrc_pkg::MOD_W'(4);
      inv2_q <= 32'd393213;
      inv3_q <= 48'd25770000386;
    end else if (cfg_we_i) begin
      unique case (smrc_pkg::cfg_idx_e'(cfg_addr_i))
        smrc_pkg::CFG_MODULUS_0:       mod0_q <= cfg_wdata_i[smrc_pkg::MOD_W-1:0];
        smrc_pkg::CFG_MODULUS_1:       mod1_q <= cfg_wdata_i[smrc_pkg::MOD_W-1:0];
        smrc_pkg::CFG_MODULUS_2:       mod2_q <= cfg_wdata_i[smrc_pkg::MOD_W-1:0];
        smrc_pkg::CFG_MODULUS_3:       mod3_q <= cfg_wdata_i[smrc_pkg::MOD_W-1:0];
        smrc_pkg::CFG_INVERSE_INTO_1:  inv1_q <= cfg_wdata_i[smrc_pkg::MOD_W-1:0];
        smrc_pkg::CFG_INVERSES_INTO_2: inv2_q <= cfg_wdata_i[2*smrc_pkg::INV_W-1:0];
        smrc_pkg::CFG_INVERSES_INTO_3: inv3_q <= cfg_wdata_i[3*smrc_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  // running products of moduli, registered in w2_q and then in w3_q after a write
  always_ff @(posedge clk_i) begin
    w2_q <= mod0_q * mod1_q;
    w3_q <= w2_q * mod2_q;
  end

  // pipeline advances unless the skid register is occupied
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  assign r0 = s_axis_tdata[14:0];
  assign r1 = s_axis_tdata[29:15];
  assign r2 = s_axis_tdata[44:30];
  assign r3 = s_axis_tdata[59:45];

  function automatic smrc_pkg::diff_t sub_res(smrc_pkg::res_t a, smrc_pkg::res_t b);
    sub_res = smrc_pkg::diff_t'(a) - smrc_pkg::diff_t'(b);
  endfunction

  // level 0: all residues against digit 0
  smrc_mulred u_red10 (.clk_i, .en_i(en), .diff_i(sub_res(r1, r0)),
    .inv_i(smrc_pkg::inv_t'($signed(inv1_q))), .mod_i(mod1_q), .res_o(d1));
  smrc_mulred u_red20 (.clk_i, .en_i(en), .diff_i(sub_res(r2, r0)),
    .inv_i(inv2_q[15:0]), .mod_i(mod2_q), .res_o(t20));
  smrc_mulred u_red30 (.clk_i, .en_i(en), .diff_i(sub_res(r3, r0)),
    .inv_i(inv3_q[15:0]), .mod_i(mod3_q), .res_o(t30));

  assign dg_in0 = '{d0: r0, d1: '0, d2: '0};
  smrc_delay u_dly0 (.clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid && en),
    .data_i(dg_in0), .valid_o(v0), .data_o(dg_out0));

  // level 1: against digit 1
  smrc_mulred u_red21 (.clk_i, .en_i(en), .diff_i(sub_res(t20, d1)),
    .inv_i(inv2_q[31:16]), .mod_i(mod2_q), .res_o(d2));
  smrc_mulred u_red31 (.clk_i, .en_i(en), .diff_i(sub_res(t30, d1)),
    .inv_i(inv3_q[31:16]), .mod_i(mod3_q), .res_o(t31));

  assign dg_in1 = '{d0: dg_out0.d0, d1: d1, d2: '0};
  smrc_delay u_dly1 (.clk_i, .rst_ni, .en_i(en), .valid_i(v0),
    .data_i(dg_in1), .valid_o(v1), .data_o(dg_out1));

  // level 2: against digit 2
  smrc_mulred u_red32 (.clk_i, .en_i(en), .diff_i(sub_res(t31, d2)),
    .inv_i(inv3_q[47:32]), .mod_i(mod3_q), .res_o(d3));

  assign dg_in2 = '{d0: dg_out1.d0, d1: dg_out1.d1, d2: d2};
  smrc_delay u_dly2 (.clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .data_i(dg_in2), .valid_o(v2), .data_o(dg_out2));

  // weighting and sum
  smrc_accum u_accum (.clk_i, .rst_ni, .en_i(en), .valid_i(v2),
    .digits_i(dg_out2), .d3_i(d3), .w1_i(mod0_q), .w2_i(w2_q), .w3_i(w3_q),
    .valid_o(acc_valid), .value_o(acc_value));

  // output register with skid
  assign out_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= acc_valid;
      end
    end else if (en && acc_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_q <= skid_valid_q ? skid_q : acc_value;
    end else if (en && acc_valid) begin
      skid_q <= acc_value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = smrc_pkg::M_TDATA_W'(out_q);

  // the skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid full with empty output register");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid filled without a stalled output");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("skid value dropped while output stalled");

endmodule

FILE: bench/tb.sv
// self-checking bench for the symmetric mixed-radix converter
module tb;

  // expected binary values and a private copy of the register file
  class value_scoreboard;
    logic [14:0]  modulus [4];
    logic [14:0]  inv_into_1;
    logic [31:0]  inv_into_2;
    logic [47:0]  inv_into_3;
    logic [61:0]  pending_values [$];
    int           errors;

    function new();
      modulus = '{15'd7, 15'd9, 15'd11, 15'd13};
      inv_into_1 = 15'd4;
      inv_into_2 = 32'd393213;
      inv_into_3 = 48'd25770000386;
      errors = 0;
    endfunction

    function void write_reg(smrc_pkg::cfg_idx_e idx, logic [47:0] val);
      case (idx)
        smrc_pkg::CFG_MODULUS_0:       modulus[0] = val[14:0];
        smrc_pkg::CFG_MODULUS_1:       modulus[1] = val[14:0];
        smrc_pkg::CFG_MODULUS_2:       modulus[2] = val[14:0];
        smrc_pkg::CFG_MODULUS_3:       modulus[3] = val[14:0];
        smrc_pkg::CFG_INVERSE_INTO_1:  inv_into_1 = val[14:0];
        smrc_pkg::CFG_INVERSES_INTO_2: inv_into_2 = val[31:0];
        smrc_pkg::CFG_INVERSES_INTO_3: inv_into_3 = val[47:0];
        default: ;
      endcase
    endfunction

    // symmetric remainder, truncating division as in signed integer maths
    function longint sym_reduce(longint x, longint p);
      longint half, r;
      if (p == 0) return 0;
      half = p / 2;
      r = x % p;
      if (r > half) r -= p;
      else if (r < -half) r += p;
      return r;
    endfunction

    function longint inverse_of(int j, int i);
      if (i == 1) return longint'($signed(inv_into_1));
      if (i == 2) return longint'($signed(inv_into_2[16*j +: 16]));
      return longint'($signed(inv_into_3[16*j +: 16]));
    endfunction

    // mixed-radix digits, weighted by running products of the moduli
    function void note_residues(logic [63:0] d);
      longint digit [4];
      longint acc, weight, v, p;
      logic [14:0] r;
      digit[0] = longint'($signed(d[14:0]));
      acc = digit[0];
      weight = 1;
      for (int i = 1; i < 4; i++) begin
        p = longint'(modulus[i]);
        r = d[15*i +: 15];
        v = longint'($signed(r));
        for (int j = 0; j < i; j++)
          v = sym_reduce((v - digit[j]) * inverse_of(j, i), p);
        v = sym_reduce(v, p);
        digit[i] = v;
        weight = weight * longint'(modulus[i-1]);
        acc = acc + weight * v;
      end
      pending_values.push_back(acc[61:0]);
    endfunction

    function void check_value(logic [61:0] actual);
      logic [61:0] expected;
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, actual);
        errors++;
        return;
      end
      expected = pending_values.pop_front();
      if (actual !== expected) begin
        $display("%0t: binary_value mismatch, expected %h, actual %h",
                 $time, expected, actual);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [47:0] cfg_wdata_i;

  value_scoreboard sb;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          hold_off_cycles;
  int          cycle_count;

  localparam int TIMEOUT_CYCLES = 500000;
  localparam int DRAIN_CYCLES   = 45;

  symmetric_mixed_radix_conversion u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transaction monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_residues(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_value(m_axis_tdata[61:0]);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        m_axis_tready = 1'b0;
        hold_off_cycles--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  task automatic send_residues(logic [63:0] d);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [14:0] r0, logic [14:0] r1,
                             logic [14:0] r2, logic [14:0] r3);
    send_residues({4'b0, r3, r2, r1, r0});
  endtask

  // wait for every result, then for the pipeline to settle
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending_values.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(smrc_pkg::cfg_idx_e idx, logic [47:0] val);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // residue within the symmetric range of a modulus
  function automatic logic [14:0] in_range(logic [14:0] p);
    int half;
    half = int'(p) / 2;
    return 15'($urandom_range(2 * half) - half);
  endfunction

  initial begin
    logic [47:0] vals [7];
    logic [14:0] r [4];
    sb = new();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_cycles    = 0;
    cycle_count        = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = smrc_pkg::CFG_MODULUS_0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: residue extremes with the default base, digit zero unreduced
    send_fields(15'd0, 15'd0, 15'd0, 15'd0);
    send_fields(15'd3, 15'd4, 15'd5, 15'd6);
    send_fields(-15'sd3, -15'sd4, -15'sd5, -15'sd6);
    send_fields(15'sd16383, 15'sd16383, 15'sd16383, 15'sd16383);
    send_fields(-15'sd16383, -15'sd16383, -15'sd16383, -15'sd16383);
    send_fields(15'h4000, 15'h4000, 15'h4000, 15'h4000);
    send_fields(15'h7fff, 15'h0001, 15'h7fff, 15'h0001);
    send_fields(15'd1, 15'd0, 15'd0, 15'd0);
    send_fields(15'd0, 15'd1, 15'd0, 15'd0);
    send_fields(15'd0, 15'd0, 15'd1, 15'd0);
    send_fields(15'd0, 15'd0, 15'd0, 15'd1);
    send_fields(15'h5555, 15'h2aaa, 15'h5555, 15'h2aaa);
    drain();

    // moduli at their largest, inverses at the signed extremes
    vals = '{48'h7fff, 48'h7fff, 48'h7fff, 48'h7fff, 48'h3fff,
             48'h8000_7fff, 48'h8001_7fff_8000};
    foreach (vals[k]) write_reg(smrc_pkg::cfg_idx_e'(k), vals[k]);
    send_fields(15'sd16383, -15'sd16383, 15'sd16383, -15'sd16383);
    send_fields(-15'sd16383, 15'sd16383, -15'sd16383, 15'sd16383);
    send_fields(15'h4000, 15'h3fff, 15'h4000, 15'h3fff);
    drain();

    // smallest moduli
    vals = '{48'd2, 48'd2, 48'd2, 48'd2, 48'h4001, 48'hffff_ffff, 48'hffff_ffff_ffff};
    foreach (vals[k]) write_reg(smrc_pkg::cfg_idx_e'(k), vals[k]);
    send_fields(15'd1, 15'd1, 15'd1, 15'd1);
    send_fields(-15'sd1, 15'd1, -15'sd1, 15'd1);
    send_fields(15'sd16383, 15'h4000, 15'sd16383, 15'h4000);
    drain();

    // random phases, each with its own base and idling profile
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
        default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
      endcase
      for (int k = 0; k < 4; k++) vals[k] = 48'($urandom_range(2, 32767));
      if (ph == 3) vals[0] = 48'd32767;
      if (ph == 6) vals[3] = 48'd2;
      vals[4] = 48'($urandom_range(0, 32767));
      vals[5] = 48'($urandom);
      vals[6] = {16'($urandom), 32'($urandom)};
      foreach (vals[k]) write_reg(smrc_pkg::cfg_idx_e'(k), vals[k]);
      // long receiver hold-off so the pipeline fills and stalls the input
      if (ph == 0) hold_off_cycles = 300;
      for (int n = 0; n < 240; n++) begin
        if ($urandom_range(1)) begin
          for (int k = 0; k < 4; k++) r[k] = 15'($urandom);
        end else begin
          for (int k = 0; k < 4; k++) r[k] = in_range(sb.modulus[k]);
        end
        send_fields(r[0], r[1], r[2], r[3]);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_values.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
